// ----- src/fsa_pkg.sv -----
// fsa_pkg: opcodes, status codes, port widths and RAM control type
// for the free list slot allocator. No dependencies.
package fsa_pkg;

  localparam int OPCODE_W   = 2;
  localparam int INDEX_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 10;
  localparam int PORT_PAY_W = 32;

  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOP     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

endpackage

// ----- src/fsa_ram.sv -----
// fsa_ram: simple dual-port synchronous RAM with registered read.
// Depends on fsa_pkg for the control struct.
module fsa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  fsa_pkg::ram_ctl_t    ctl,
  input  logic [$clog2(D)-1:0] rd_addr,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  output logic [W-1:0]         rd_data
);
  import fsa_pkg::*;

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/fsa_ctrl.sv -----
// fsa_ctrl: two-state sequencer, free head and watermark registers,
// read-modify-write of the slot RAMs and the result register. Uses fsa_pkg.
module fsa_ctrl #(
  parameter int SLOTS        = 1024,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [fsa_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [fsa_pkg::INDEX_W-1:0]         in_slot_index,
  input  logic [fsa_pkg::PORT_PAY_W-1:0]      in_payload_in,
  output fsa_pkg::ram_ctl_t                   st_ctl,
  output logic [$clog2(SLOTS)-1:0]            st_rd_addr,
  output logic [$clog2(SLOTS)-1:0]            wr_addr,
  output logic [$clog2(SLOTS+1):0]            st_wr_data,
  input  logic [$clog2(SLOTS+1):0]            st_rd_data,
  output fsa_pkg::ram_ctl_t                   pay_ctl,
  output logic [$clog2(SLOTS)-1:0]            pay_rd_addr,
  output logic [PAYLOAD_BITS-1:0]             pay_wr_data,
  input  logic [PAYLOAD_BITS-1:0]             pay_rd_data,
  output logic                                out_strobe,
  output logic [fsa_pkg::STATUS_W-1:0]        out_status,
  output logic [fsa_pkg::SLOT_OUT_W-1:0]      out_slot_out,
  output logic [fsa_pkg::PORT_PAY_W-1:0]      out_payload_out,
  output logic                                out_occupied_out
);
  import fsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [HW-1:0]         head_r, head_nxt;
  logic [HW-1:0]         wm_r, wm_nxt;
  logic [OPCODE_W-1:0]   op_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [PORT_PAY_W-1:0] data_r;
  logic                  accept;

  logic                  st_we, pay_we;
  logic [STATUS_W-1:0]   status_nxt;
  logic [SLOT_OUT_W-1:0] slot_nxt;
  logic [PORT_PAY_W-1:0] pay_nxt;
  logic                  occ_nxt;
  logic                  idx_bad, idx_touched, occ_rd;

  logic                  strobe_r;
  logic [STATUS_W-1:0]   status_r;
  logic [SLOT_OUT_W-1:0] slot_r;
  logic [PORT_PAY_W-1:0] pay_r;
  logic                  occ_r;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && (state_r == S_IDLE);

  // reads issue at the transfer edge, writes land in the execute cycle
  assign st_rd_addr  = (in_opcode == OP_ALLOC) ? IW'(head_r) : IW'(in_slot_index);
  assign pay_rd_addr = IW'(in_slot_index);
  assign st_ctl      = '{rd_en: accept, wr_en: st_we};
  assign pay_ctl     = '{rd_en: accept, wr_en: pay_we};
  assign wr_addr     = (op_r == OP_ALLOC) ? IW'(head_r) : IW'(idx_r);
  assign pay_wr_data = PAYLOAD_BITS'(data_r);

  assign idx_bad     = (32'(idx_r) >= 32'(SLOTS));
  assign idx_touched = (32'(idx_r) < 32'(wm_r));
  assign occ_rd      = idx_touched && st_rd_data[HW];

  assign state_nxt = accept ? S_EXEC : S_IDLE;

  always_comb begin
    head_nxt   = head_r;
    wm_nxt     = wm_r;
    st_we      = 1'b0;
    pay_we     = 1'b0;
    st_wr_data = {1'b1, st_rd_data[HW-1:0]};
    status_nxt = ST_OK;
    slot_nxt   = '0;
    pay_nxt    = '0;
    occ_nxt    = 1'b0;
    if (state_r == S_EXEC) begin
      case (op_r)
        OP_ALLOC: begin
          if (head_r >= HW'(SLOTS)) begin
            status_nxt = ST_FULL;
          end else begin
            if (head_r >= wm_r) begin
              head_nxt = head_r + 1'b1;
              wm_nxt   = head_r + 1'b1;
            end else begin
              head_nxt = st_rd_data[HW-1:0];
            end
            st_we    = 1'b1;
            pay_we   = 1'b1;
            slot_nxt = SLOT_OUT_W'(head_r);
          end
        end
        OP_RELEASE: begin
          if (idx_bad) begin
            status_nxt = ST_RANGE;
          end else if (!occ_rd) begin
            status_nxt = ST_FREE;
            slot_nxt   = SLOT_OUT_W'(idx_r);
          end else begin
            st_we      = 1'b1;
            st_wr_data = {1'b0, head_r};
            head_nxt   = HW'(idx_r);
            slot_nxt   = SLOT_OUT_W'(idx_r);
          end
        end
        OP_READ: begin
          if (idx_bad) begin
            status_nxt = ST_RANGE;
          end else begin
            slot_nxt = SLOT_OUT_W'(idx_r);
            pay_nxt  = idx_touched ? PORT_PAY_W'(pay_rd_data) : '0;
            occ_nxt  = occ_rd;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      wm_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      wm_r     <= wm_nxt;
      strobe_r <= (state_r == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      idx_r  <= in_slot_index;
      data_r <= in_payload_in;
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      pay_r    <= pay_nxt;
      occ_r    <= occ_nxt;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_slot_out     = slot_r;
  assign out_payload_out  = pay_r;
  assign out_occupied_out = occ_r;

endmodule

// ----- src/free_list_slot_allocator.sv -----
// free_list_slot_allocator: top level, slot state RAM (occupied + link),
// payload RAM and the sequencer. Depends on fsa_pkg, fsa_ram, fsa_ctrl.
//
//  channel  ports                                     transfer when
//  input    in_opcode, in_slot_index, in_payload_in   start && !busy
//  result   out_status, out_slot_out,                 out_strobe
//           out_payload_out, out_occupied_out
//
// Per item, the RAM read is issued at the transfer edge, then the execute
// state does the read-modify-write; busy is high during execute.
// The result shows on out_strobe in the cycle after execute, while the next
// item may already be taken. Slot state past the watermark reads as free,
// so no clearing pass runs after reset; reset clears head and watermark.
// The result side cannot stall.
module free_list_slot_allocator #(
  parameter int SLOTS        = 1024,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [fsa_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [fsa_pkg::INDEX_W-1:0]    in_slot_index,
  input  logic [fsa_pkg::PORT_PAY_W-1:0] in_payload_in,
  output logic                           out_strobe,
  output logic [fsa_pkg::STATUS_W-1:0]   out_status,
  output logic [fsa_pkg::SLOT_OUT_W-1:0] out_slot_out,
  output logic [fsa_pkg::PORT_PAY_W-1:0] out_payload_out,
  output logic                           out_occupied_out
);
  import fsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);

  ram_ctl_t          st_ctl, pay_ctl;
  logic [IW-1:0]     st_rd_addr, pay_rd_addr, wr_addr;
  logic [HW:0]       st_wr_data, st_rd_data;
  logic [PAYLOAD_BITS-1:0] pay_wr_data, pay_rd_data;

  fsa_ram #(.W(HW + 1), .D(SLOTS)) u_st_ram (
    .clk     (clk),
    .ctl     (st_ctl),
    .rd_addr (st_rd_addr),
    .wr_addr (wr_addr),
    .wr_data (st_wr_data),
    .rd_data (st_rd_data)
  );

  fsa_ram #(.W(PAYLOAD_BITS), .D(SLOTS)) u_pay_ram (
    .clk     (clk),
    .ctl     (pay_ctl),
    .rd_addr (pay_rd_addr),
    .wr_addr (wr_addr),
    .wr_data (pay_wr_data),
    .rd_data (pay_rd_data)
  );

  fsa_ctrl #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_slot_index    (in_slot_index),
    .in_payload_in    (in_payload_in),
    .st_ctl           (st_ctl),
    .st_rd_addr       (st_rd_addr),
    .wr_addr          (wr_addr),
    .st_wr_data       (st_wr_data),
    .st_rd_data       (st_rd_data),
    .pay_ctl          (pay_ctl),
    .pay_rd_addr      (pay_rd_addr),
    .pay_wr_data      (pay_wr_data),
    .pay_rd_data      (pay_rd_data),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_payload_out  (out_payload_out),
    .out_occupied_out (out_occupied_out)
  );

endmodule

// ----- src/fsa_checker.sv -----
// fsa_checker: port-level assertions for free_list_slot_allocator,
// bound to the top level. Uses fsa_pkg status codes.
module fsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic [fsa_pkg::STATUS_W-1:0]   out_status,
  input logic [fsa_pkg::SLOT_OUT_W-1:0] out_slot_out,
  input logic [fsa_pkg::PORT_PAY_W-1:0] out_payload_out,
  input logic                           out_occupied_out
);
  import fsa_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result missing two cycles after input transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("strobe longer than one cycle");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FULL || out_status == ST_RANGE)) |->
      (out_slot_out == '0 && out_payload_out == '0 && !out_occupied_out))
    else $error("error result carries nonzero fields");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (!out_occupied_out && out_payload_out == '0))
    else $error("failed request returned slot data");

endmodule

bind free_list_slot_allocator fsa_checker u_fsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_slot_out     (out_slot_out),
  .out_payload_out  (out_payload_out),
  .out_occupied_out (out_occupied_out)
);
